@@ sv/ubd_pkg.sv @@
// Shared types, constants and status codes of the bidirectional UTF-8 decoder.
package ubd_pkg;

    // Longest legal UTF-8 sequence.
    localparam int MAX_SEQ_BYTES = 4;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Code point limits for each sequence length.
    localparam logic [20:0] CP_MIN_2   = 21'h00080;
    localparam logic [20:0] CP_MAX_2   = 21'h007FF;
    localparam logic [20:0] CP_MIN_3   = 21'h00800;
    localparam logic [20:0] CP_MAX_3   = 21'h0FFFF;
    localparam logic [20:0] CP_SURR_LO = 21'h0D800;
    localparam logic [20:0] CP_SURR_HI = 21'h0DFFF;
    localparam logic [20:0] CP_MIN_4   = 21'h10000;
    localparam logic [20:0] CP_MAX_4   = 21'h10FFFF;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_TOO_LONG   = 2'd1,
        STATUS_BAD_STRUCT = 2'd2,
        STATUS_BAD_VALUE  = 2'd3
    } status_t;

    // One input request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } ubd_in_t;

    // One result request.
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_length;
        status_t     status;
        logic        is_separator;
    } ubd_result_t;

    // A classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
        logic [2:0] lead_len;   // 1..4, or 0 for a byte that cannot lead
        logic       is_cont;    // byte has the form 10xxxxxx
    } ubd_item_t;

endpackage

@@ sv/ubd_front.sv @@
// Front end: accepts input bytes, classifies them and queues them for the back end.
module ubd_front #(
    parameter int DEPTH = ubd_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ubd_pkg::ubd_in_t  s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output ubd_pkg::ubd_item_t q_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ubd_pkg::ubd_item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    ubd_pkg::ubd_item_t new_item;
    logic push;
    logic pop;

    // Sequence length announced by a lead byte.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        priority if (b[7] == 1'b0)       n = 3'd1;
        else if (b[7:5] == 3'b110)       n = 3'd2;
        else if (b[7:4] == 4'b1110)      n = 3'd3;
        else if (b[7:3] == 5'b11110)     n = 3'd4;
        else                             n = 3'd0;
        return n;
    endfunction

    // Classify the incoming byte.
    always_comb begin
        new_item.data_byte = s_data.data_byte;
        new_item.line_end  = s_data.line_end;
        new_item.lead_len  = lead_length(s_data.data_byte);
        new_item.is_cont   = (s_data.data_byte[7:6] == 2'b10);
    end

    assign s_ready = (count_reg != CW'(DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_item  = mem[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

@@ sv/ubd_back.sv @@
// Back end: holds the decoder state, assembles code points and drives the result register.
module ubd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ubd_pkg::ubd_item_t   q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ubd_pkg::ubd_result_t m_data
);

    logic        reverse_reg;
    logic [20:0] partial_reg, partial_next;
    logic [2:0]  seen_reg, seen_next;
    logic [2:0]  exp_reg, exp_next;
    logic        out_valid_reg, out_valid_next;
    ubd_pkg::ubd_result_t out_reg, out_next;

    logic           advance;
    logic           fin;
    logic           err;
    ubd_pkg::status_t err_code;
    logic [20:0]    fin_cp;
    logic [2:0]     fin_len;
    logic           emit;
    logic [20:0]    lead_bits;
    logic [20:0]    cont_bits;
    logic [20:0]    fwd_value;
    logic [2:0]     seen_inc;
    logic [7:0]     b;

    // Payload bits that a lead byte of the given length carries.
    function automatic logic [20:0] lead_payload(input logic [7:0] v, input logic [2:0] n);
        logic [20:0] r;
        unique case (n)
            3'd2:    r = {16'd0, v[4:0]};
            3'd3:    r = {17'd0, v[3:0]};
            3'd4:    r = {18'd0, v[2:0]};
            default: r = {13'd0, v};
        endcase
        return r;
    endfunction

    // Place six-bit groups by the number of continuations taken so far.
    function automatic logic [20:0] place(input logic [20:0] v, input logic [2:0] k);
        logic [20:0] r;
        unique case (k)
            3'd0:    r = v;
            3'd1:    r = {v[14:0], 6'd0};
            3'd2:    r = {v[8:0], 12'd0};
            3'd3:    r = {v[2:0], 18'd0};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Legal code point range for the sequence length.
    function automatic logic in_range(input logic [20:0] cp, input logic [2:0] n);
        logic ok;
        unique case (n)
            3'd1:    ok = (cp < ubd_pkg::CP_MIN_2);
            3'd2:    ok = (cp >= ubd_pkg::CP_MIN_2) && (cp <= ubd_pkg::CP_MAX_2);
            3'd3:    ok = (cp >= ubd_pkg::CP_MIN_3) && (cp <= ubd_pkg::CP_MAX_3) &&
                          !((cp >= ubd_pkg::CP_SURR_LO) && (cp <= ubd_pkg::CP_SURR_HI));
            3'd4:    ok = (cp >= ubd_pkg::CP_MIN_4) && (cp <= ubd_pkg::CP_MAX_4);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Punctuation, controls and code points 80h to 8Eh count as separators.
    function automatic logic separator(input logic [20:0] c);
        return (c < 21'h30) || (c > 21'h39 && c < 21'h41) ||
               (c > 21'h5A && c < 21'h61) || (c > 21'h7A && c < 21'h8F);
    endfunction

    // The back end moves whenever the result register is free or being emptied.
    assign q_ready = !out_valid_reg || m_ready;
    assign advance = q_valid && q_ready;
    assign b       = q_item.data_byte;

    assign seen_inc  = seen_reg + 3'd1;
    assign lead_bits = lead_payload(b, q_item.lead_len);
    assign cont_bits = {15'd0, b[5:0]};
    assign fwd_value = {partial_reg[14:0], b[5:0]};

    // Decode one classified byte against the current state.
    always_comb begin
        partial_next = partial_reg;
        seen_next    = seen_reg;
        exp_next     = exp_reg;
        fin          = 1'b0;
        err          = 1'b0;
        err_code     = ubd_pkg::STATUS_BAD_STRUCT;
        fin_cp       = '0;
        fin_len      = '0;
        if (reverse_reg) begin
            if (q_item.is_cont) begin
                if (q_item.line_end) begin
                    err      = 1'b1;
                    err_code = ubd_pkg::STATUS_TOO_LONG;
                end else if (seen_reg >= 3'(ubd_pkg::MAX_SEQ_BYTES - 1)) begin
                    err = 1'b1;
                end else begin
                    partial_next = partial_reg | place(cont_bits, seen_reg);
                    seen_next    = seen_inc;
                end
            end else if (q_item.lead_len == 3'd0 || q_item.lead_len != seen_inc) begin
                err = 1'b1;
            end else begin
                fin     = 1'b1;
                fin_cp  = partial_reg | place(lead_bits, seen_reg);
                fin_len = q_item.lead_len;
            end
        end else if (exp_reg == 3'd0) begin
            // No sequence open: the byte must be a lead.
            if (q_item.lead_len == 3'd1) begin
                fin     = 1'b1;
                fin_cp  = {13'd0, b};
                fin_len = 3'd1;
            end else if (q_item.lead_len == 3'd0) begin
                err = 1'b1;
            end else if (q_item.line_end) begin
                err      = 1'b1;
                err_code = ubd_pkg::STATUS_TOO_LONG;
            end else begin
                partial_next = lead_bits;
                seen_next    = 3'd1;
                exp_next     = q_item.lead_len;
            end
        end else if (!q_item.is_cont) begin
            err = 1'b1;
        end else begin
            partial_next = fwd_value;
            seen_next    = seen_inc;
            if (seen_inc >= exp_reg) begin
                fin     = 1'b1;
                fin_cp  = fwd_value;
                fin_len = exp_reg;
            end else if (q_item.line_end) begin
                err      = 1'b1;
                err_code = ubd_pkg::STATUS_TOO_LONG;
            end
        end
    end

    assign emit = fin || err;

    // Build the next result and return to idle after any result.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
            if (fin && in_range(fin_cp, fin_len)) begin
                out_next.code_point   = fin_cp;
                out_next.byte_length  = fin_len;
                out_next.status       = ubd_pkg::STATUS_OK;
                out_next.is_separator = separator(fin_cp);
            end else begin
                out_next.code_point   = '0;
                out_next.byte_length  = '0;
                out_next.status       = fin ? ubd_pkg::STATUS_BAD_VALUE : err_code;
                out_next.is_separator = 1'b0;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Decoder state and mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_reg <= 1'b0;
            partial_reg <= '0;
            seen_reg    <= '0;
            exp_reg     <= '0;
        end else if (cfg_wr_en) begin
            reverse_reg <= cfg_wr_data;
            partial_reg <= '0;
            seen_reg    <= '0;
            exp_reg     <= '0;
        end else if (advance) begin
            if (emit) begin
                partial_reg <= '0;
                seen_reg    <= '0;
                exp_reg     <= '0;
            end else begin
                partial_reg <= partial_next;
                seen_reg    <= seen_next;
                exp_reg     <= exp_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // An error result carries no code point and no length.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ubd_pkg::STATUS_OK) |->
        (m_data.code_point == '0 && m_data.byte_length == '0 && !m_data.is_separator))
        else $error("error result with nonzero payload");

    // A good result has a legal length.
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ubd_pkg::STATUS_OK) |->
        (m_data.byte_length != 3'd0 && m_data.byte_length <= 3'(ubd_pkg::MAX_SEQ_BYTES)))
        else $error("good result with bad length");

    // After a result is produced the decoder is idle.
    a_idle_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && !cfg_wr_en) |=>
        (partial_reg == '0 && seen_reg == '0 && exp_reg == '0))
        else $error("state not cleared after result");

    // Reverse decoding never opens a forward sequence length.
    a_rev_noexp: assert property (@(posedge aclk) disable iff (!aresetn)
        reverse_reg |-> (exp_reg == '0 && seen_reg < 3'(ubd_pkg::MAX_SEQ_BYTES)))
        else $error("reverse mode with forward state");

endmodule

@@ sv/utf8_bidirectional_decoder_unit.sv @@
// Top level of the bidirectional validating UTF-8 decoder.
//
// The decoder takes one byte per cycle while the result side keeps up, in line order or
// from the line end backwards as the reverse_reg mode bit selects, and gives one result
// for each finished character or error. A byte is classified on entry and parked in a
// small queue (QUEUE_DEPTH entries); the back end consumes one queued byte per cycle
// whenever its result register is free or being emptied, and the result of the byte
// that completes a character is written to that result register. The rate is set by
// the decode step in the back end, which updates the partial code point and byte count
// for each byte. Writing the mode bit drops any open sequence and returns the decoder
// to idle; write it only while no bytes are in flight.
module utf8_bidirectional_decoder_unit #(
    parameter int QUEUE_DEPTH = ubd_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ubd_pkg::ubd_in_t     s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ubd_pkg::ubd_result_t m_data
);

    logic               q_valid;
    logic               q_ready;
    ubd_pkg::ubd_item_t q_item;

    // Classify and queue incoming bytes.
    ubd_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // Decode queued bytes into results.
    ubd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

@@ tb/utf8_bidirectional_decoder_unit_tb.sv @@
// Self-checking testbench for the bidirectional UTF-8 decoder: directed table, random lines.
`timescale 1ns / 100ps

module utf8_bidirectional_decoder_unit_tb;

    // Values of the direction register.
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    localparam int DIRECTED_ROWS = 25;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_PRINTS    = 50;

    // Kinds of character that the random line builder produces.
    typedef enum int {
        CK_VALID      = 0,
        CK_OVERLONG   = 1,
        CK_SURROGATE  = 2,
        CK_TOO_BIG    = 3,
        CK_TRUNCATED  = 4,
        CK_EXTRA_CONT = 5,
        CK_NOISE      = 6
    } char_kind_t;

    // One row of the directed table; want is only used when has_want is set.
    typedef struct packed {
        logic                 mode;
        logic [7:0]           data_byte;
        logic                 line_end;
        logic                 has_want;
        ubd_pkg::ubd_result_t want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    ubd_pkg::ubd_in_t     s_data;
    logic                 m_valid;
    logic                 m_ready;
    ubd_pkg::ubd_result_t m_data;

    // Typed expectation that travels alongside the request on the input channel.
    logic                 has_want_q;
    ubd_pkg::ubd_result_t want_q;

    // Shared stimulus controls.
    logic        hold_wanted;
    logic        tail_quiet;

    // Decoder state as the scoreboard tracks it.
    logic        rev_mode;
    logic [20:0] cp_acc;
    logic [2:0]  taken;
    logic [2:0]  seq_len;

    ubd_pkg::ubd_result_t pending_chars [$];
    logic [7:0]           line_bytes [$];
    dir_row_t             directed_rows [DIRECTED_ROWS];
    int                   mismatch_count = 0;

    utf8_bidirectional_decoder_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // 100 MHz clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    function automatic void clear_sequence();
        cp_acc  = '0;
        taken   = '0;
        seq_len = '0;
    endfunction

    // Sequence length that a lead byte announces, or 0 when it cannot lead.
    function automatic logic [2:0] lead_len_of(input logic [7:0] b);
        if (b[7] == 1'b0) return 3'd1;
        if (b[7:5] == 3'b110) return 3'd2;
        if (b[7:4] == 4'b1110) return 3'd3;
        if (b[7:3] == 5'b11110) return 3'd4;
        return 3'd0;
    endfunction

    function automatic bit fail_with(input ubd_pkg::status_t st,
                                     output ubd_pkg::ubd_result_t res);
        res.code_point   = '0;
        res.byte_length  = '0;
        res.status       = st;
        res.is_separator = 1'b0;
        clear_sequence();
        return 1'b1;
    endfunction

    // Range check of a finished character, then the separator classification.
    function automatic bit finish_char(input logic [20:0] cp, input logic [2:0] n,
                                       output ubd_pkg::ubd_result_t res);
        logic ok;
        case (n)
            3'd1: ok = cp < ubd_pkg::CP_MIN_2;
            3'd2: ok = cp >= ubd_pkg::CP_MIN_2 && cp <= ubd_pkg::CP_MAX_2;
            3'd3: ok = cp >= ubd_pkg::CP_MIN_3 && cp <= ubd_pkg::CP_MAX_3 &&
                       !(cp >= ubd_pkg::CP_SURR_LO && cp <= ubd_pkg::CP_SURR_HI);
            default: ok = cp >= ubd_pkg::CP_MIN_4 && cp <= ubd_pkg::CP_MAX_4;
        endcase
        if (!ok) return fail_with(ubd_pkg::STATUS_BAD_VALUE, res);
        res.code_point   = cp;
        res.byte_length  = n;
        res.status       = ubd_pkg::STATUS_OK;
        res.is_separator = (cp < 21'h30) || (cp > 21'h39 && cp < 21'h41) ||
                           (cp > 21'h5A && cp < 21'h61) || (cp > 21'h7A && cp < 21'h8F);
        clear_sequence();
        return 1'b1;
    endfunction

    // Advances the tracked state by one byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output ubd_pkg::ubd_result_t res);
        logic [2:0] n;
        res = '0;
        if (rev_mode == DIR_FWD) begin
            // Forward: the lead byte opens the sequence, continuations append low bits.
            if (seq_len == 3'd0) begin
                n = lead_len_of(b);
                if (n == 3'd1) return finish_char({13'd0, b}, n, res);
                if (n == 3'd0) return fail_with(ubd_pkg::STATUS_BAD_STRUCT, res);
                if (last) return fail_with(ubd_pkg::STATUS_TOO_LONG, res);
                cp_acc  = {13'd0, b & (8'h7F >> n)};
                taken   = 3'd1;
                seq_len = n;
                return 1'b0;
            end
            if (b[7:6] != 2'b10) return fail_with(ubd_pkg::STATUS_BAD_STRUCT, res);
            cp_acc = {cp_acc[14:0], b[5:0]};
            taken  = taken + 3'd1;
            if (taken >= seq_len) return finish_char(cp_acc, seq_len, res);
            if (last) return fail_with(ubd_pkg::STATUS_TOO_LONG, res);
            return 1'b0;
        end
        // Reverse: continuations come first and fill from the low end, the lead closes.
        if (b[7:6] == 2'b10) begin
            if (last) return fail_with(ubd_pkg::STATUS_TOO_LONG, res);
            if (taken >= 3'(ubd_pkg::MAX_SEQ_BYTES - 1)) begin
                return fail_with(ubd_pkg::STATUS_BAD_STRUCT, res);
            end
            cp_acc = cp_acc | ({15'd0, b[5:0]} << (6 * taken));
            taken  = taken + 3'd1;
            return 1'b0;
        end
        n = lead_len_of(b);
        if (n == 3'd0 || {1'b0, n} != {1'b0, taken} + 4'd1) begin
            return fail_with(ubd_pkg::STATUS_BAD_STRUCT, res);
        end
        if (n == 3'd1) return finish_char({13'd0, b}, n, res);
        cp_acc = cp_acc | ({13'd0, b & (8'h7F >> n)} << (6 * taken));
        return finish_char(cp_acc, n, res);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: checks results, follows register writes, predicts requests
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : scoreboard
        ubd_pkg::ubd_result_t res;
        ubd_pkg::ubd_result_t want;
        bit                   produced;
        if (!aresetn) begin
            rev_mode = DIR_FWD;
            clear_sequence();
        end else begin
            // Compare each delivered result with the oldest expectation.
            if (m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    note_mismatch("result with nothing expected", m_data, 0);
                end else begin
                    want = pending_chars.pop_front();
                    if (m_data.code_point !== want.code_point)
                        note_mismatch("code_point", m_data.code_point, want.code_point);
                    if (m_data.byte_length !== want.byte_length)
                        note_mismatch("byte_length", m_data.byte_length, want.byte_length);
                    if (m_data.status !== want.status)
                        note_mismatch("status", m_data.status, want.status);
                    if (m_data.is_separator !== want.is_separator)
                        note_mismatch("is_separator", m_data.is_separator,
                                      want.is_separator);
                end
            end
            // A direction write drops any open sequence.
            if (cfg_wr_en) begin
                rev_mode = cfg_wr_data;
                clear_sequence();
            end
            // Each accepted request advances the prediction.
            if (s_valid && s_ready) begin
                produced = decode_byte(s_data.data_byte, s_data.line_end, res);
                if (has_want_q) begin
                    pending_chars.push_back(want_q);
                end else if (produced) begin
                    pending_chars.push_back(res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random line construction
    // ------------------------------------------------------------------

    function automatic void push_encoded(input logic [20:0] cp, input int len);
        case (len)
            1: line_bytes.push_back({1'b0, cp[6:0]});
            2: begin
                line_bytes.push_back({3'b110, cp[10:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                line_bytes.push_back({4'b1110, cp[15:12]});
                line_bytes.push_back({2'b10, cp[11:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                line_bytes.push_back({5'b11110, cp[20:18]});
                line_bytes.push_back({2'b10, cp[17:12]});
                line_bytes.push_back({2'b10, cp[11:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // A legal scalar value for the given length, often at one end of its range.
    function automatic logic [20:0] legal_cp(input int len);
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        case (len)
            1: begin lo = '0;                hi = ubd_pkg::CP_MIN_2 - 21'd1; end
            2: begin lo = ubd_pkg::CP_MIN_2; hi = ubd_pkg::CP_MAX_2; end
            3: begin lo = ubd_pkg::CP_MIN_3; hi = ubd_pkg::CP_MAX_3; end
            default: begin lo = ubd_pkg::CP_MIN_4; hi = ubd_pkg::CP_MAX_4; end
        endcase
        case ($urandom_range(0, 3))
            0: cp = lo;
            1: cp = hi;
            default: cp = $urandom_range(lo, hi);
        endcase
        // Move a surrogate up out of the surrogate range, into F800h to FFFFh.
        if (cp >= ubd_pkg::CP_SURR_LO && cp <= ubd_pkg::CP_SURR_HI) cp = cp ^ 21'h02000;
        return cp;
    endfunction

    // Builds one line, mostly legal characters, in the order the decoder will see it.
    task automatic build_line(input logic dir);
        int          n_chars;
        int          k;
        int          r;
        int          len;
        int          last_idx;
        logic [20:0] cp;
        logic [7:0]  rnd_byte;
        logic [7:0]  swap;
        char_kind_t  kind;
        line_bytes.delete();
        n_chars = $urandom_range(1, 6);
        for (k = 0; k < n_chars; k++) begin
            r    = $urandom_range(0, 19);
            kind = (r < 14) ? CK_VALID : char_kind_t'(r - 13);
            len  = $urandom_range(2, 4);
            case (kind)
                CK_VALID: begin
                    len = $urandom_range(1, 4);
                    push_encoded(legal_cp(len), len);
                end
                CK_OVERLONG: begin
                    case (len)
                        2: cp = $urandom_range(0, ubd_pkg::CP_MIN_2 - 21'd1);
                        3: cp = $urandom_range(0, ubd_pkg::CP_MIN_3 - 21'd1);
                        default: cp = $urandom_range(0, ubd_pkg::CP_MIN_4 - 21'd1);
                    endcase
                    push_encoded(cp, len);
                end
                CK_SURROGATE: begin
                    push_encoded($urandom_range(ubd_pkg::CP_SURR_LO, ubd_pkg::CP_SURR_HI), 3);
                end
                CK_TOO_BIG: begin
                    push_encoded($urandom_range(ubd_pkg::CP_MAX_4 + 21'd1, 21'h1FFFFF), 4);
                end
                CK_TRUNCATED: begin
                    push_encoded(legal_cp(len), len);
                    line_bytes.delete(line_bytes.size() - 1);
                end
                CK_EXTRA_CONT: begin
                    push_encoded(legal_cp(len), len);
                    rnd_byte = $urandom_range(0, 63);
                    line_bytes.push_back(8'h80 | rnd_byte);
                end
                default: begin
                    rnd_byte = $urandom_range(0, 255);
                    line_bytes.push_back(rnd_byte);
                end
            endcase
        end
        // Reverse mode reads the line from its end.
        if (dir == DIR_REV) begin
            last_idx = line_bytes.size() - 1;
            for (k = 0; k < line_bytes.size() / 2; k++) begin
                swap                       = line_bytes[k];
                line_bytes[k]              = line_bytes[last_idx - k];
                line_bytes[last_idx - k]   = swap;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    function automatic dir_row_t row_free(input logic mode, input logic [7:0] b,
                                          input logic last);
        dir_row_t r;
        r           = '0;
        r.mode      = mode;
        r.data_byte = b;
        r.line_end  = last;
        return r;
    endfunction

    function automatic dir_row_t row_want(input logic mode, input logic [7:0] b,
                                          input logic last, input logic [20:0] cp,
                                          input logic [2:0] len,
                                          input ubd_pkg::status_t st,
                                          input logic sep);
        dir_row_t r;
        r                   = row_free(mode, b, last);
        r.has_want          = 1'b1;
        r.want.code_point   = cp;
        r.want.byte_length  = len;
        r.want.status       = st;
        r.want.is_separator = sep;
        return r;
    endfunction

    // Offers one request, sometimes after an idle burst, and returns at its acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic has_want,
                             input ubd_pkg::ubd_result_t want);
        if (!tail_quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_data     <= {b, last};
        has_want_q <= has_want;
        want_q     <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Waits for every expected result, then lets the pipeline settle.
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_chars.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_chars.size() != 0) begin
            note_mismatch("results never delivered", 0, pending_chars.size());
            pending_chars.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_direction(input logic dir);
        s_valid <= 1'b0;
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int   i;
        int   p;
        int   sent;
        logic cur_dir;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = DIR_FWD;
        has_want_q  = 1'b0;
        want_q      = '0;
        hold_wanted = 1'b0;
        tail_quiet  = 1'b0;

        // Extremes, bad leads, range errors and line ends in both directions.
        directed_rows = '{
            row_want(DIR_FWD, 8'h00, 1'b0, 21'h0, 3'd1, ubd_pkg::STATUS_OK, 1'b1),
            row_want(DIR_FWD, 8'h7F, 1'b1, 21'h7F, 3'd1, ubd_pkg::STATUS_OK, 1'b1),
            row_free(DIR_FWD, 8'hC3, 1'b0),
            row_free(DIR_FWD, 8'hA9, 1'b0),
            row_free(DIR_FWD, 8'hF4, 1'b0),
            row_free(DIR_FWD, 8'h8F, 1'b0),
            row_free(DIR_FWD, 8'hBF, 1'b0),
            row_want(DIR_FWD, 8'hBF, 1'b1, ubd_pkg::CP_MAX_4, 3'd4, ubd_pkg::STATUS_OK, 1'b0),
            row_free(DIR_FWD, 8'hC0, 1'b0),
            row_want(DIR_FWD, 8'h80, 1'b0, 21'h0, 3'd0, ubd_pkg::STATUS_BAD_VALUE, 1'b0),
            row_free(DIR_FWD, 8'hED, 1'b0),
            row_free(DIR_FWD, 8'hA0, 1'b0),
            row_want(DIR_FWD, 8'h80, 1'b0, 21'h0, 3'd0, ubd_pkg::STATUS_BAD_VALUE, 1'b0),
            row_want(DIR_FWD, 8'h80, 1'b0, 21'h0, 3'd0, ubd_pkg::STATUS_BAD_STRUCT, 1'b0),
            row_want(DIR_FWD, 8'hFF, 1'b0, 21'h0, 3'd0, ubd_pkg::STATUS_BAD_STRUCT, 1'b0),
            row_want(DIR_FWD, 8'hE2, 1'b1, 21'h0, 3'd0, ubd_pkg::STATUS_TOO_LONG, 1'b0),
            row_free(DIR_FWD, 8'hC3, 1'b0),
            row_want(DIR_FWD, 8'h41, 1'b1, 21'h0, 3'd0, ubd_pkg::STATUS_BAD_STRUCT, 1'b0),
            row_want(DIR_REV, 8'h80, 1'b1, 21'h0, 3'd0, ubd_pkg::STATUS_TOO_LONG, 1'b0),
            row_free(DIR_REV, 8'hBF, 1'b0),
            row_free(DIR_REV, 8'hBF, 1'b0),
            row_free(DIR_REV, 8'hBF, 1'b0),
            row_want(DIR_REV, 8'hBF, 1'b0, 21'h0, 3'd0, ubd_pkg::STATUS_BAD_STRUCT, 1'b0),
            row_free(DIR_REV, 8'h80, 1'b0),
            row_want(DIR_REV, 8'h41, 1'b1, 21'h0, 3'd0, ubd_pkg::STATUS_BAD_STRUCT, 1'b0)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        cur_dir = DIR_FWD;
        set_direction(cur_dir);

        // Directed table.
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].mode != cur_dir) begin
                cur_dir = directed_rows[i].mode;
                set_direction(cur_dir);
            end
            send_byte(directed_rows[i].data_byte, directed_rows[i].line_end,
                      directed_rows[i].has_want, directed_rows[i].want);
        end

        // Random lines, alternating direction; the receiver holds off once,
        // and the last phase runs without idling.
        for (p = 0; p < RAND_PHASES; p++) begin
            cur_dir = p[0] ? DIR_FWD : DIR_REV;
            set_direction(cur_dir);
            if (p == 1) hold_wanted = 1'b1;
            tail_quiet = (p == RAND_PHASES - 1);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_line(cur_dir);
                for (i = 0; i < line_bytes.size(); i++) begin
                    send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'b0, '0);
                    sent++;
                end
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls and one long hold-off
    // ------------------------------------------------------------------

    initial begin : result_sink
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_wanted && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!tail_quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Ends a run that hangs.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
